/* rtl/e2q_pkg.sv */
package e2q_pkg;

	localparam int ANGLE_WIDTH     = 16;
	localparam int COMPONENT_WIDTH = 16;
	localparam int CORDIC_STEPS    = 16;

	// pipeline depths
	localparam int LANE_LAT = CORDIC_STEPS + 3;
	localparam int MAT_LAT  = 5;
	localparam int SQ_LAT   = 32;
	localparam int DIV_LAT  = 35;
	localparam int TOT_LAT  = LANE_LAT + MAT_LAT + SQ_LAT + DIV_LAT + 1;

	localparam int COMP_SH  = 30 - (COMPONENT_WIDTH - 2);

	// sin, cos and matrix terms, q30
	typedef logic signed [33:0] q30_t;
	// wide q30 for angles, trace and radicands
	typedef logic signed [35:0] ang_t;
	// numerators and quotients, q30
	typedef logic signed [34:0] num_t;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_M11   = 2'd1,
		BR_M22   = 2'd2,
		BR_M33   = 2'd3
	} br_t;

	typedef struct packed {
		logic [32:0] rad;
		br_t         br;
		num_t        n0;
		num_t        n1;
		num_t        n2;
	} mat_res_t;

	typedef struct packed {
		br_t  br;
		num_t n0;
		num_t n1;
		num_t n2;
	} sq_side_t;

	typedef struct packed {
		br_t         br;
		logic [30:0] hr;
	} dv_side_t;

	localparam ang_t PI_Q30     = 36'sd3373259426;
	localparam ang_t TWO_PI_Q30 = 36'sd6746518852;
	localparam ang_t HPI_Q30    = 36'sd1686629713;
	localparam ang_t ONE_Q30    = 36'sd1073741824;

	// elaboration-time helpers for the cordic constants
	function automatic longint unsigned isqrt64(input longint unsigned n_in);
		longint unsigned n;
		longint unsigned res;
		longint unsigned bit_v;
		int k;
		n = n_in;
		res = 64'd0;
		bit_v = 64'd1 << 62;
		for (k = 0; k < 32; k++) begin
			if (n >= res + bit_v) begin
				n = n - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// shift and subtract quotient, elaboration time only
	function automatic longint unsigned udiv64(input longint unsigned n,
		input longint unsigned d);
		logic [64:0] r;
		longint unsigned q;
		int b;
		r = '0;
		q = 64'd0;
		for (b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic q30_t atan_step(input int i);
		longint unsigned v;
		longint unsigned term;
		longint unsigned kk;
		int k;
		v = 64'd0;
		if (i == 0) begin
			v = 64'h1921FB54442D1846;
		end else begin
			for (k = 1; k * i <= 61; k += 2) begin
				kk = 64'(k);
				term = udiv64(64'd1 << (61 - k * i), kk);
				if (((k - 1) / 2) % 2 == 0)
					v = v + term;
				else
					v = v - term;
			end
		end
		v = (v + (64'd1 << 30)) >> 31;
		return q30_t'(v[33:0]);
	endfunction

	function automatic q30_t cordic_gain();
		longint unsigned kg;
		longint unsigned den;
		longint unsigned v;
		longint unsigned c;
		int i;
		kg = 64'd1 << 30;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			den = (64'd1 << (2 * i)) + 64'd1;
			v = (64'd1 << 60) - udiv64(64'd1 << 60, den);
			c = isqrt64(v);
			kg = (kg * c + (64'd1 << 29)) >> 30;
		end
		return q30_t'(kg[33:0]);
	endfunction

	// q30 product rounded half up
	function automatic q30_t mul30(input q30_t a, input q30_t b);
		logic signed [67:0] p;
		p = a * b + 68'sd536870912;
		return q30_t'(p >>> 30);
	endfunction

	// q30 to output format, round half up, saturate to +-1.0
	function automatic logic signed [COMPONENT_WIDTH-1:0] comp_out(input num_t v);
		logic signed [35:0] t;
		logic signed [35:0] lim;
		t = (36'(v) + (36'sd1 <<< (COMP_SH - 1))) >>> COMP_SH;
		lim = 36'sd1 <<< (COMPONENT_WIDTH - 2);
		if (t > lim)
			t = lim;
		if (t < -lim)
			t = -lim;
		return t[COMPONENT_WIDTH-1:0];
	endfunction

endpackage

/* rtl/e2q_lane.sv */
module e2q_lane (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0] angle,
	output e2q_pkg::q30_t                         sn,
	output e2q_pkg::q30_t                         cs
);

	localparam int S = e2q_pkg::CORDIC_STEPS;
	localparam e2q_pkg::q30_t GAIN = e2q_pkg::cordic_gain();

	e2q_pkg::ang_t a_ext;
	e2q_pkg::ang_t z_wrap_s1;
	e2q_pkg::ang_t z_s    [S+1];
	e2q_pkg::q30_t x_s    [S+1];
	e2q_pkg::q30_t y_s    [S+1];
	logic          flip_s [S+1];
	e2q_pkg::q30_t sn_q;
	e2q_pkg::q30_t cs_q;

	assign a_ext = e2q_pkg::ang_t'(angle) <<< (34 - e2q_pkg::ANGLE_WIDTH);

	// wrap into [-pi, pi]
	always_ff @(posedge clk) begin
		if (en) begin
			if (a_ext > e2q_pkg::PI_Q30)
				z_wrap_s1 <= a_ext - e2q_pkg::TWO_PI_Q30;
			else if (a_ext < -e2q_pkg::PI_Q30)
				z_wrap_s1 <= a_ext + e2q_pkg::TWO_PI_Q30;
			else
				z_wrap_s1 <= a_ext;
		end
	end

	// fold into [-pi/2, pi/2] by a half turn
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= GAIN;
			y_s[0] <= '0;
			if (z_wrap_s1 > e2q_pkg::HPI_Q30) begin
				z_s[0]    <= z_wrap_s1 - e2q_pkg::PI_Q30;
				flip_s[0] <= 1'b1;
			end else if (z_wrap_s1 < -e2q_pkg::HPI_Q30) begin
				z_s[0]    <= z_wrap_s1 + e2q_pkg::PI_Q30;
				flip_s[0] <= 1'b1;
			end else begin
				z_s[0]    <= z_wrap_s1;
				flip_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < S; i++) begin : g_step
		localparam e2q_pkg::q30_t ATAN_I = e2q_pkg::atan_step(i);
		e2q_pkg::q30_t dx;
		e2q_pkg::q30_t dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - e2q_pkg::ang_t'(ATAN_I);
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + e2q_pkg::ang_t'(ATAN_I);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_q <= flip_s[S] ? -y_s[S] : y_s[S];
			cs_q <= flip_s[S] ? -x_s[S] : x_s[S];
		end
	end

	assign sn = sn_q;
	assign cs = cs_q;

endmodule

/* rtl/e2q_matrix.sv */
module e2q_matrix (
	input  logic               clk,
	input  logic               en,
	input  e2q_pkg::q30_t      sa,
	input  e2q_pkg::q30_t      ca,
	input  e2q_pkg::q30_t      sb,
	input  e2q_pkg::q30_t      cb,
	input  e2q_pkg::q30_t      sc,
	input  e2q_pkg::q30_t      cc,
	input  logic [15:0]        trace_floor,
	output e2q_pkg::mat_res_t  res
);

	// first products
	e2q_pkg::q30_t g_s1, h_s1, ii_s1, jj_s1, p13_s1, p21_s1, m22_s1, m33_s1, sa_s1;
	// second products
	e2q_pkg::q30_t a1_s2, a2_s2, a3_s2, a4_s2;
	e2q_pkg::q30_t g_s2, h_s2, ii_s2, jj_s2, p13_s2, p21_s2, m22_s2, m33_s2, sa_s2;
	// matrix terms
	e2q_pkg::q30_t m11_s3, m12_s3, m13_s3, m21_s3, m22_s3, m23_s3, m31_s3, m32_s3, m33_s3;
	// trace, radicands, numerators
	e2q_pkg::ang_t tr_s4, rad1_s4, rad2_s4, rad3_s4;
	logic          c11_s4, c22_s4;
	e2q_pkg::num_t dx_s4, dy_s4, dz_s4, p12_s4, p13_s4, p23_s4, dw1_s4, dw3_s4;
	e2q_pkg::mat_res_t res_s5;

	e2q_pkg::ang_t floor_w;
	e2q_pkg::ang_t rad_sel;
	e2q_pkg::mat_res_t res_d;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1   <= e2q_pkg::mul30(cb, cc);
			h_s1   <= e2q_pkg::mul30(sb, cc);
			ii_s1  <= e2q_pkg::mul30(sb, sc);
			jj_s1  <= e2q_pkg::mul30(cb, sc);
			p13_s1 <= e2q_pkg::mul30(sb, ca);
			p21_s1 <= e2q_pkg::mul30(ca, sc);
			m22_s1 <= e2q_pkg::mul30(ca, cc);
			m33_s1 <= e2q_pkg::mul30(ca, cb);
			sa_s1  <= sa;

			a1_s2  <= e2q_pkg::mul30(sa_s1, ii_s1);
			a2_s2  <= e2q_pkg::mul30(sa_s1, h_s1);
			a3_s2  <= e2q_pkg::mul30(sa_s1, jj_s1);
			a4_s2  <= e2q_pkg::mul30(sa_s1, g_s1);
			g_s2   <= g_s1;
			h_s2   <= h_s1;
			ii_s2  <= ii_s1;
			jj_s2  <= jj_s1;
			p13_s2 <= p13_s1;
			p21_s2 <= p21_s1;
			m22_s2 <= m22_s1;
			m33_s2 <= m33_s1;
			sa_s2  <= sa_s1;

			m11_s3 <= g_s2 - a1_s2;
			m12_s3 <= a2_s2 + jj_s2;
			m13_s3 <= -p13_s2;
			m21_s3 <= -p21_s2;
			m22_s3 <= m22_s2;
			m23_s3 <= sa_s2;
			m31_s3 <= h_s2 + a3_s2;
			m32_s3 <= ii_s2 - a4_s2;
			m33_s3 <= m33_s2;

			tr_s4   <= e2q_pkg::ang_t'(m11_s3) + e2q_pkg::ang_t'(m22_s3)
				+ e2q_pkg::ang_t'(m33_s3) + e2q_pkg::ONE_Q30;
			rad1_s4 <= e2q_pkg::ONE_Q30 + e2q_pkg::ang_t'(m11_s3)
				- e2q_pkg::ang_t'(m22_s3) - e2q_pkg::ang_t'(m33_s3);
			rad2_s4 <= e2q_pkg::ONE_Q30 + e2q_pkg::ang_t'(m22_s3)
				- e2q_pkg::ang_t'(m11_s3) - e2q_pkg::ang_t'(m33_s3);
			rad3_s4 <= e2q_pkg::ONE_Q30 + e2q_pkg::ang_t'(m33_s3)
				- e2q_pkg::ang_t'(m11_s3) - e2q_pkg::ang_t'(m22_s3);
			c11_s4  <= (m11_s3 > m22_s3) && (m11_s3 > m33_s3);
			c22_s4  <= m22_s3 > m33_s3;
			dx_s4   <= e2q_pkg::num_t'(m32_s3) - e2q_pkg::num_t'(m23_s3);
			dy_s4   <= e2q_pkg::num_t'(m13_s3) - e2q_pkg::num_t'(m31_s3);
			dz_s4   <= e2q_pkg::num_t'(m21_s3) - e2q_pkg::num_t'(m12_s3);
			p12_s4  <= e2q_pkg::num_t'(m12_s3) + e2q_pkg::num_t'(m21_s3);
			p13_s4  <= e2q_pkg::num_t'(m13_s3) + e2q_pkg::num_t'(m31_s3);
			p23_s4  <= e2q_pkg::num_t'(m23_s3) + e2q_pkg::num_t'(m32_s3);
			dw1_s4  <= e2q_pkg::num_t'(m23_s3) - e2q_pkg::num_t'(m32_s3);
			dw3_s4  <= e2q_pkg::num_t'(m12_s3) - e2q_pkg::num_t'(m21_s3);

			res_s5 <= res_d;
		end
	end

	assign floor_w = e2q_pkg::ang_t'({trace_floor, 16'd0});

	// branch choice, radicand clamp and numerator routing
	always_comb begin
		res_d = '0;
		rad_sel = tr_s4;
		if (tr_s4 > floor_w) begin
			res_d.br = e2q_pkg::BR_TRACE;
			rad_sel  = tr_s4;
		end else if (c11_s4) begin
			res_d.br = e2q_pkg::BR_M11;
			rad_sel  = rad1_s4;
		end else if (c22_s4) begin
			res_d.br = e2q_pkg::BR_M22;
			rad_sel  = rad2_s4;
		end else begin
			res_d.br = e2q_pkg::BR_M33;
			rad_sel  = rad3_s4;
		end
		if (rad_sel < 36'sd1)
			res_d.rad = 33'd1;
		else if (rad_sel > (36'sd1 <<< 32))
			res_d.rad = 33'd1 << 32;
		else
			res_d.rad = rad_sel[32:0];
		case (res_d.br)
			e2q_pkg::BR_TRACE: begin
				res_d.n0 = dx_s4;
				res_d.n1 = dy_s4;
				res_d.n2 = dz_s4;
			end
			e2q_pkg::BR_M11: begin
				res_d.n0 = p12_s4;
				res_d.n1 = p13_s4;
				res_d.n2 = dw1_s4;
			end
			e2q_pkg::BR_M22: begin
				res_d.n0 = p12_s4;
				res_d.n1 = p23_s4;
				res_d.n2 = dy_s4;
			end
			default: begin
				res_d.n0 = p13_s4;
				res_d.n1 = p23_s4;
				res_d.n2 = dw3_s4;
			end
		endcase
	end

	assign res = res_s5;

endmodule

/* rtl/e2q_sqrt.sv */
module e2q_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] rad,
	output logic [31:0] root
);

	localparam int N = e2q_pkg::SQ_LAT;

	logic [63:0] n_in   [N];
	logic [63:0] res_in [N];
	logic [63:0] n_s    [N];
	logic [63:0] res_s  [N];

	// one result bit per stage, floor root
	for (genvar k = 0; k < N; k++) begin : g_st
		localparam logic [63:0] BIT_K = 64'd1 << (62 - 2 * k);
		logic [63:0] t;
		if (k == 0) begin : g_first
			assign n_in[k]   = {1'b0, rad, 30'd0};
			assign res_in[k] = '0;
		end else begin : g_next
			assign n_in[k]   = n_s[k-1];
			assign res_in[k] = res_s[k-1];
		end
		assign t = res_in[k] + BIT_K;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_in[k] >= t) begin
					n_s[k]   <= n_in[k] - t;
					res_s[k] <= (res_in[k] >> 1) + BIT_K;
				end else begin
					n_s[k]   <= n_in[k];
					res_s[k] <= res_in[k] >> 1;
				end
			end
		end
	end

	assign root = res_s[N-1][31:0];

endmodule

/* rtl/e2q_div.sv */
module e2q_div (
	input  logic          clk,
	input  logic          en,
	input  e2q_pkg::num_t num,
	input  logic [31:0]   root,
	output e2q_pkg::num_t quo
);

	// setup stage, 33 quotient bits, sign stage
	localparam int QB = 33;

	logic [33:0] mag;
	logic [33:0] mag_c;
	logic [63:0] dvd;
	logic [32:0] dsr;

	logic [63:0] rem_s [QB+1];
	logic [32:0] d_s   [QB+1];
	logic [32:0] q_s   [QB+1];
	logic        ovf_s [QB+1];
	logic        neg_s [QB+1];
	e2q_pkg::num_t quo_q;

	assign mag   = num[34] ? 34'(-num) : num[33:0];
	assign mag_c = (mag > (34'd1 << 33)) ? (34'd1 << 33) : mag;
	assign dvd   = {mag_c, 30'd0} + 64'(root);
	assign dsr   = {root, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dvd;
			d_s[0]   <= dsr;
			q_s[0]   <= '0;
			ovf_s[0] <= {3'd0, dvd} >= ({34'd0, dsr} << QB);
			neg_s[0] <= num[34];
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_st
		localparam int K = QB - j;
		logic [66:0] dk;
		assign dk = {34'd0, d_s[j-1]} << K;
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j]   <= d_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				neg_s[j] <= neg_s[j-1];
				if ({3'd0, rem_s[j-1]} >= dk) begin
					rem_s[j] <= rem_s[j-1] - dk[63:0];
					q_s[j]   <= q_s[j-1] | (33'd1 << K);
				end else begin
					rem_s[j] <= rem_s[j-1];
					q_s[j]   <= q_s[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[QB])
				quo_q <= neg_s[QB] ? -(35'sd1 <<< 33) : (35'sd1 <<< 33);
			else
				quo_q <= neg_s[QB] ? -e2q_pkg::num_t'({2'b00, q_s[QB]})
					: e2q_pkg::num_t'({2'b00, q_s[QB]});
		end
	end

	assign quo = quo_q;

endmodule

/* rtl/euler_to_quaternion.sv */
// euler angles to unit quaternion
//
// input channel: in_valid/in_ready with angle_x, angle_y, angle_z in radians,
// signed q4.12; a beat is taken when both are high
// output channel: out_valid/out_ready with quat_x..quat_w (signed q2.14,
// saturated to +-1.0) and branch_taken (0 trace, 1/2/3 largest m11/m22/m33)
// config channel: cfg_valid/cfg_ready with cfg_data writing trace_floor
// (units of 2^-14); cfg_ready is always high, write only while idle
// from input beat to output beat a beat passes each sin/cos lane (wrap, fold,
// 16 cordic steps, sign), the matrix and branch merge, the square root, the
// dividers and 1 output register
// throughput is one beat per cycle while the receiver keeps up; the whole pipe advances as one
// when the receiver stalls with a result waiting, the pipe freezes and
// in_ready drops until out_ready returns
// reset clears all valid bits and loads trace_floor with 2
module euler_to_quaternion (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0]    angle_x,
	input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0]    angle_y,
	input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0]    angle_z,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [e2q_pkg::COMPONENT_WIDTH-1:0] quat_x,
	output logic signed [e2q_pkg::COMPONENT_WIDTH-1:0] quat_y,
	output logic signed [e2q_pkg::COMPONENT_WIDTH-1:0] quat_z,
	output logic signed [e2q_pkg::COMPONENT_WIDTH-1:0] quat_w,
	output logic [1:0]                                branch_taken,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [15:0]                               cfg_data
);

	localparam int L = e2q_pkg::TOT_LAT;

	logic adv;
	logic vld_q [L];
	logic [15:0] trace_floor_q;

	e2q_pkg::q30_t sa, ca, sb, cb, sc, cc;
	e2q_pkg::mat_res_t mres;
	logic [31:0] root;
	e2q_pkg::num_t q0, q1, q2;
	e2q_pkg::num_t hr_w;

	e2q_pkg::sq_side_t sq_side_s [e2q_pkg::SQ_LAT];
	e2q_pkg::dv_side_t dv_side_s [e2q_pkg::DIV_LAT];

	logic signed [e2q_pkg::COMPONENT_WIDTH-1:0] qx_q, qy_q, qz_q, qw_q;
	e2q_pkg::br_t br_q;

	// the pipe moves unless a finished beat is waiting at the output
	assign adv      = !vld_q[L-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[L-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_floor_q <= 16'd2;
		end else if (cfg_valid) begin
			trace_floor_q <= cfg_data;
		end
	end

	// valid bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < L; k++)
				vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < L; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	// three sin/cos lanes side by side
	e2q_lane u_lane_x (.clk(clk), .en(adv), .angle(angle_x), .sn(sa), .cs(ca));
	e2q_lane u_lane_y (.clk(clk), .en(adv), .angle(angle_y), .sn(sb), .cs(cb));
	e2q_lane u_lane_z (.clk(clk), .en(adv), .angle(angle_z), .sn(sc), .cs(cc));

	// matrix terms, trace test and branch merge
	e2q_matrix u_matrix (
		.clk(clk), .en(adv),
		.sa(sa), .ca(ca), .sb(sb), .cb(cb), .sc(sc), .cc(cc),
		.trace_floor(trace_floor_q),
		.res(mres)
	);

	e2q_sqrt u_sqrt (.clk(clk), .en(adv), .rad(mres.rad), .root(root));

	// numerators ride alongside the square root
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_side_s[0] <= '{br: mres.br, n0: mres.n0, n1: mres.n1, n2: mres.n2};
			for (int k = 1; k < e2q_pkg::SQ_LAT; k++)
				sq_side_s[k] <= sq_side_s[k-1];
		end
	end

	e2q_div u_div0 (.clk(clk), .en(adv), .num(sq_side_s[e2q_pkg::SQ_LAT-1].n0),
		.root(root), .quo(q0));
	e2q_div u_div1 (.clk(clk), .en(adv), .num(sq_side_s[e2q_pkg::SQ_LAT-1].n1),
		.root(root), .quo(q1));
	e2q_div u_div2 (.clk(clk), .en(adv), .num(sq_side_s[e2q_pkg::SQ_LAT-1].n2),
		.root(root), .quo(q2));

	// half root and branch ride alongside the dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_side_s[0] <= '{br: sq_side_s[e2q_pkg::SQ_LAT-1].br,
				hr: 31'((33'(root) + 33'd1) >> 1)};
			for (int k = 1; k < e2q_pkg::DIV_LAT; k++)
				dv_side_s[k] <= dv_side_s[k-1];
		end
	end

	assign hr_w = e2q_pkg::num_t'({4'd0, dv_side_s[e2q_pkg::DIV_LAT-1].hr});

	// place the half root by branch, round and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			br_q <= dv_side_s[e2q_pkg::DIV_LAT-1].br;
			case (dv_side_s[e2q_pkg::DIV_LAT-1].br)
				e2q_pkg::BR_TRACE: begin
					qx_q <= e2q_pkg::comp_out(q0);
					qy_q <= e2q_pkg::comp_out(q1);
					qz_q <= e2q_pkg::comp_out(q2);
					qw_q <= e2q_pkg::comp_out(hr_w);
				end
				e2q_pkg::BR_M11: begin
					qx_q <= e2q_pkg::comp_out(hr_w);
					qy_q <= e2q_pkg::comp_out(q0);
					qz_q <= e2q_pkg::comp_out(q1);
					qw_q <= e2q_pkg::comp_out(q2);
				end
				e2q_pkg::BR_M22: begin
					qx_q <= e2q_pkg::comp_out(q0);
					qy_q <= e2q_pkg::comp_out(hr_w);
					qz_q <= e2q_pkg::comp_out(q1);
					qw_q <= e2q_pkg::comp_out(q2);
				end
				default: begin
					qx_q <= e2q_pkg::comp_out(q0);
					qy_q <= e2q_pkg::comp_out(q1);
					qz_q <= e2q_pkg::comp_out(hr_w);
					qw_q <= e2q_pkg::comp_out(q2);
				end
			endcase
		end
	end

	assign quat_x       = qx_q;
	assign quat_y       = qy_q;
	assign quat_z       = qz_q;
	assign quat_w       = qw_q;
	assign branch_taken = br_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	localparam int LATENCY = e2q_pkg::TOT_LAT;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} angles_t;

	typedef struct {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		e2q_pkg::br_t       br;
	} quat_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] angle_x, angle_y, angle_z;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0] branch_taken;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;
	logic in_ready_seen;

	euler_to_quaternion DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.branch_taken(branch_taken),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// pending angle beats, expected quaternions, shadow copy of the floor
	angles_t pending_angles[$];
	quat_t   expected_quats[$];
	logic [15:0] floor_shadow;

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	bit fail_seen;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- fixed point helpers for the predictor

	function automatic longint asr_l(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint rmul(longint a, longint b);
		return asr_l(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n_in);
		longint unsigned n, res, b;
		n = n_in;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// arctan(2^-i), alternating series in q61 then rounded to q30
	function automatic longint atan_q30(int i);
		longint unsigned v, term;
		int k;
		v = 0;
		if (i == 0) begin
			v = 64'h1921FB54442D1846;
		end else begin
			for (k = 1; k * i <= 61; k += 2) begin
				term = (64'd1 << (61 - k * i)) / longint'(k);
				if (((k - 1) / 2) % 2 == 0)
					v += term;
				else
					v -= term;
			end
		end
		return longint'((v + (64'd1 << 30)) >> 31);
	endfunction

	function automatic longint gain_q30();
		longint unsigned kg, den, v;
		int i;
		kg = 64'd1 << 30;
		for (i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin
			den = (64'd1 << (2 * i)) + 1;
			v = (64'd1 << 60) - (64'd1 << 60) / den;
			kg = (kg * int_sqrt(v) + (64'd1 << 29)) >> 30;
		end
		return longint'(kg);
	endfunction

	// cordic sine and cosine of a q4.12 angle, q30 out
	task automatic angle_sincos(input logic signed [15:0] raw, output longint sn,
		output longint cs);
		longint a, x, y, z, dx, dy, pi, hp;
		bit flip;
		int i;
		pi = 64'sd3373259426;
		hp = pi >>> 1;
		a = longint'(raw) <<< 18;
		flip = 0;
		if (a > pi)
			a -= 2 * pi;
		else if (a < -pi)
			a += 2 * pi;
		if (a > hp) begin
			a -= pi;
			flip = 1;
		end else if (a < -hp) begin
			a += pi;
			flip = 1;
		end
		x = gain_q30();
		y = 0;
		z = a;
		for (i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin
			dx = asr_l(y, i);
			dy = asr_l(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_q30(i);
			end else begin
				x += dx; y -= dy; z += atan_q30(i);
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endtask

	// num / (2 root), magnitude rounded half up then signed
	function automatic longint half_quot(longint num, longint unsigned root);
		longint unsigned d, mag, q;
		d = 2 * root;
		mag = num < 0 ? longint'(-num) : num;
		if (mag > (64'd1 << 33))
			mag = 64'd1 << 33;
		q = ((mag << 30) + d / 2) / d;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [15:0] to_q2_14(longint v);
		longint t, lim;
		t = asr_l(v + (64'sd1 <<< 15), 16);
		lim = 64'sd1 <<< 14;
		if (t > lim)
			t = lim;
		if (t < -lim)
			t = -lim;
		return t[15:0];
	endfunction

	// full conversion: matrix, trace method branch, sqrt and quotients
	task automatic predict_quat(input angles_t a, output quat_t q);
		longint sa, ca, sb, cb, sc, cc, g, h, ii, jj;
		longint m11, m12, m13, m21, m22, m23, m31, m32, m33, tr, rad;
		longint qx, qy, qz, qw, one;
		longint unsigned r, hr;
		e2q_pkg::br_t br;
		one = 64'sd1 <<< 30;
		angle_sincos(a.ax, sa, ca);
		angle_sincos(a.ay, sb, cb);
		angle_sincos(a.az, sc, cc);
		g = rmul(cb, cc);
		h = rmul(sb, cc);
		ii = rmul(sb, sc);
		jj = rmul(cb, sc);
		m11 = g - rmul(sa, ii);
		m12 = rmul(sa, h) + jj;
		m13 = -rmul(sb, ca);
		m21 = -rmul(ca, sc);
		m22 = rmul(ca, cc);
		m23 = sa;
		m31 = h + rmul(sa, jj);
		m32 = -rmul(sa, g) + ii;
		m33 = rmul(ca, cb);
		tr = m11 + m22 + m33 + one;
		if (tr > (longint'(floor_shadow) <<< 16)) begin
			br = e2q_pkg::BR_TRACE; rad = tr;
		end else if (m11 > m22 && m11 > m33) begin
			br = e2q_pkg::BR_M11; rad = one + m11 - m22 - m33;
		end else if (m22 > m33) begin
			br = e2q_pkg::BR_M22; rad = one + m22 - m11 - m33;
		end else begin
			br = e2q_pkg::BR_M33; rad = one + m33 - m11 - m22;
		end
		// radicand clamped to one lsb below, 4.0 above
		if (rad < 1)
			rad = 1;
		if (rad > (64'sd1 <<< 32))
			rad = 64'sd1 <<< 32;
		r = int_sqrt(longint'(rad) << 30);
		hr = (r + 1) >> 1;
		case (br)
			e2q_pkg::BR_TRACE: begin
				qx = half_quot(m32 - m23, r); qy = half_quot(m13 - m31, r);
				qz = half_quot(m21 - m12, r); qw = hr;
			end
			e2q_pkg::BR_M11: begin
				qx = hr; qy = half_quot(m12 + m21, r);
				qz = half_quot(m13 + m31, r); qw = half_quot(m23 - m32, r);
			end
			e2q_pkg::BR_M22: begin
				qx = half_quot(m12 + m21, r); qy = hr;
				qz = half_quot(m23 + m32, r); qw = half_quot(m13 - m31, r);
			end
			default: begin
				qx = half_quot(m13 + m31, r); qy = half_quot(m23 + m32, r);
				qz = hr; qw = half_quot(m12 - m21, r);
			end
		endcase
		q.qx = to_q2_14(qx);
		q.qy = to_q2_14(qy);
		q.qz = to_q2_14(qz);
		q.qw = to_q2_14(qw);
		q.br = br;
	endtask

	// ---------------- driver: one angle beat from the queue, change on falling edge

	initial begin
		in_valid = 1'b0;
		angle_x = '0;
		angle_y = '0;
		angle_z = '0;
	end

	always @(negedge clk) begin
		quat_t q;
		// a beat accepted at the last rising edge leaves the queue and is predicted
		if (in_valid && in_ready_seen) begin
			predict_quat(pending_angles[0], q);
			expected_quats.push_back(q);
			void'(pending_angles.pop_front());
		end
		if (!in_valid || in_ready_seen) begin
			if (pending_angles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				angle_x <= pending_angles[0].ax;
				angle_y <= pending_angles[0].ay;
				angle_z <= pending_angles[0].az;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// handshake sampled at the rising edge and consumed by the driver on the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_ready_seen <= 1'b0;
		else
			in_ready_seen <= in_valid && in_ready;
	end

	// ---------------- monitor: compare each result beat with the oldest prediction

	always @(posedge clk) begin
		quat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_quats.size() == 0) begin
				fail_seen = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat at %0t", $realtime);
			end else begin
				e = expected_quats.pop_front();
				if (quat_x !== e.qx || quat_y !== e.qy || quat_z !== e.qz ||
					quat_w !== e.qw || branch_taken !== e.br) begin
					fail_seen = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0d br %0d, got %0d %0d %0d %0d br %0d",
							e.qx, e.qy, e.qz, e.qw, e.br,
							quat_x, quat_y, quat_z, quat_w, branch_taken);
				end
			end
		end
	end

	// ---------------- stimulus

	task automatic add_angles(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] z);
		angles_t a;
		a.ax = x;
		a.ay = y;
		a.az = z;
		pending_angles.push_back(a);
	endtask

	// random angle: mostly in the principal range, sometimes full field
	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(9))
			0, 1: return 16'($urandom);
			2: return 16'(int'($urandom_range(0, 400)) - 200);
			3: return $urandom_range(1) ? 16'sd6434 : -16'sd6434;
			default: return 16'(int'($urandom_range(0, 25736)) - 12868);
		endcase
	endfunction

	// wait until every beat is out and the pipe has drained
	task automatic drain();
		while (pending_angles.size() > 0 || expected_quats.size() > 0 || in_valid)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_floor(input logic [15:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		floor_shadow = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_run(input int n, input int idle_pct, input int stall_pct);
		int i;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (i = 0; i < n; i++)
			add_angles(rand_angle(), rand_angle(), rand_angle());
		drain();
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		floor_shadow = 16'd2;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		fail_seen = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset floor, field extremes, wrap and fold, each axis alone
		add_angles(0, 0, 0);
		add_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		add_angles(-16'sh8000, -16'sh8000, -16'sh8000);
		add_angles(16'sd12868, 0, 0);    // x half turn, forces a diagonal branch
		add_angles(0, 16'sd12868, 0);
		add_angles(0, 0, 16'sd12868);
		add_angles(-16'sd12868, 0, 0);
		add_angles(16'sd12869, 0, 0);    // just past pi, wraps
		add_angles(16'sd6434, 0, 0);     // around pi/2, fold edge
		add_angles(16'sd6435, 0, 0);
		add_angles(0, -16'sd6435, 0);
		add_angles(16'sd12868, 16'sd12868, 0);
		add_angles(0, 16'sd12868, 16'sd12868);
		add_angles(16'sd12868, 0, 16'sd12868);
		add_angles(16'sd12868, 16'sd12868, 16'sd12868);
		add_angles(16'sd6434, 16'sd6434, 16'sd6434);
		add_angles(1, -1, 1);
		add_angles(16'sh5555, 16'shAAAA, 16'sh0F0F);
		add_angles(16'shAAAA, 16'sh5555, 16'shF0F0);
		drain();

		// floor extremes: zero, then top so diagonal branches dominate
		write_floor(16'd0);
		add_angles(16'sd12868, 0, 0);
		add_angles(0, 0, 0);
		random_run(60, 0, 0);
		write_floor(16'hFFFF);
		add_angles(0, 0, 0);
		random_run(90, 85, 0);

		// mid floor near the trace crossover
		write_floor(16'd8192);
		random_run(110, 0, 85);
		write_floor(16'd2);
		random_run(120, 19, 19);

		// bursty sender: pause until everything is back between bursts
		for (k = 0; k < 4; k++) begin
			write_floor(16'($urandom_range(0, 20000)));
			random_run(30, 0, 0);
		end
		write_floor(16'd1);
		random_run(130, 0, 0);

		if (!fail_seen && mismatches == 0)
			$display("[euler_to_quaternion] OK");
		else
			$display("[euler_to_quaternion] ERROR");
		$finish;
	end

	// ---------------- watchdog

	initial begin
		#4000000;
		$display("[euler_to_quaternion] ERROR");
		$finish;
	end

	// results still queued when the run ends keep drain waiting, since it only returns once the
	// queues are empty; the watchdog then ends the run with ERROR
endmodule

/* files.f */
rtl/e2q_pkg.sv
rtl/e2q_lane.sv
rtl/e2q_matrix.sv
rtl/e2q_sqrt.sv
rtl/e2q_div.sv
rtl/euler_to_quaternion.sv
tb/testbench.sv
